// File: design/bilinear_texel_address_gen_defines.svh
// Assertion helpers for the bilinear texel address generator.
`ifndef BILINEAR_TEXEL_ADDRESS_GEN_DEFINES_SVH
`define BILINEAR_TEXEL_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define BTAG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define BTAG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/btag_pkg.sv
package btag_pkg;

  // Fixed point format of coordinates and weights
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 18;
  localparam int CLAMP_W   = FRAC_BITS + 1;
  localparam int WGT_W     = 17;
  localparam int IDX_W     = 26;

  localparam logic [CLAMP_W-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CLAMP_W-1:0] HALF_FX = {2'b01, {(FRAC_BITS-1){1'b0}}};

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int STRIDE_CFG_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STRIDE = 2'd2;

  // Stream layout
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 144;
  localparam int OFS_MAIN    = 0;
  localparam int OFS_HOR     = OFS_MAIN + IDX_W;
  localparam int OFS_VER     = OFS_HOR + IDX_W;
  localparam int OFS_DIAG    = OFS_VER + IDX_W;
  localparam int OFS_WS      = OFS_DIAG + IDX_W;
  localparam int OFS_WT      = OFS_WS + WGT_W;
  localparam int OUT_USED_W  = OFS_WT + WGT_W;

  // Pipeline depth
  localparam int NSTG = 5;

  // Neighbor direction on one axis
  typedef enum logic [1:0] {
    NBR_NONE = 2'b00,
    NBR_PREV = 2'b01,
    NBR_NEXT = 2'b10
  } nbr_dir_t;

  // Per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

// File: design/bilinear_texel_address_gen.sv
// Channel | Dir | Contents
// in_     | in  | in_tdata: coord_s, coord_t (signed Q1.16)
// out_    | out | out_tdata: four element indices, weight_s, weight_t
// cfg_    | in  | write port: image_width, image_height, pixel_stride
//
// Five register stages; out_tvalid is the valid bit of the last one, so an item
// can leave only after passing through every stage.
// One item per cycle while not stalled; at most one multiply per stage and axis.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up while the output is stalled. Reset (synchronous) empties the
// pipeline and sets width, height and stride to 1; no clearing pass is needed.
module bilinear_texel_address_gen #(
  parameter int MAX_DIM    = 4096,
  parameter int MAX_STRIDE = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // coord_s [17:0], coord_t [35:18], zero fill [39:36]
  input  logic [btag_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // index_main [25:0], index_horizontal [51:26], index_vertical [77:52],
  // index_diagonal [103:78], weight_s [120:104], weight_t [137:121], zeros [143:138]
  output logic [btag_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [btag_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btag_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int TX_W  = $clog2(MAX_DIM);
  localparam int ST_W  = $clog2(MAX_STRIDE + 1);
  localparam int ROW_W = DIM_W + ST_W;
  localparam int NS    = btag_pkg::NSTG;

  // Configuration, stored already clamped to the legal range
  logic [DIM_W-1:0]           width_r, height_r, dim_nxt;
  logic [ST_W-1:0]            stride_r, stride_nxt;
  logic [btag_pkg::IDX_W-1:0] row_r;
  logic [btag_pkg::STRIDE_CFG_W-1:0] stride_raw;

  always_comb begin
    if (cfg_wdata == '0) begin
      dim_nxt = DIM_W'(1);
    end else if (32'(cfg_wdata) > MAX_DIM) begin
      dim_nxt = DIM_W'(MAX_DIM);
    end else begin
      dim_nxt = DIM_W'(cfg_wdata);
    end
    stride_raw = cfg_wdata[btag_pkg::STRIDE_CFG_W-1:0];
    if (stride_raw == '0) begin
      stride_nxt = ST_W'(1);
    end else if (32'(stride_raw) > MAX_STRIDE) begin
      stride_nxt = ST_W'(MAX_STRIDE);
    end else begin
      stride_nxt = ST_W'(stride_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      stride_r <= ST_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        btag_pkg::CFG_IMAGE_WIDTH:  width_r  <= dim_nxt;
        btag_pkg::CFG_IMAGE_HEIGHT: height_r <= dim_nxt;
        btag_pkg::CFG_PIXEL_STRIDE: stride_r <= stride_nxt;
        default: ;
      endcase
    end
  end

  // Row pitch in elements, follows the configuration
  always_ff @(posedge clk) begin
    row_r <= btag_pkg::IDX_W'(ROW_W'(stride_r) * ROW_W'(width_r));
  end

  // Valid chain and per-stage load enables
  logic [NS:1] valid_r, valid_nxt, rdy;
  btag_pkg::stage_en_t en;

  always_comb begin
    rdy[NS] = !valid_r[NS] || out_tready;
    for (int i = NS - 1; i >= 1; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
    valid_nxt = valid_r;
    if (rdy[1]) begin
      valid_nxt[1] = in_tvalid;
    end
    for (int i = 2; i <= NS; i++) begin
      if (rdy[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end
    end
    en.s1 = rdy[1];
    en.s2 = rdy[2];
    en.s3 = rdy[3];
    en.s4 = rdy[4];
    en.s5 = rdy[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = valid_r[NS];

  // Datapath
  logic signed [btag_pkg::COORD_W-1:0] coord_s, coord_t;
  logic [TX_W-1:0]                     tx, ty;
  logic [btag_pkg::WGT_W-1:0]          ws, wt;
  btag_pkg::nbr_dir_t                  ds, dt;
  logic [btag_pkg::IDX_W-1:0]          idx_main, idx_hor, idx_ver, idx_diag;
  logic [btag_pkg::WGT_W-1:0]          weight_s, weight_t;

  assign coord_s = in_tdata[0 +: btag_pkg::COORD_W];
  assign coord_t = in_tdata[btag_pkg::COORD_W +: btag_pkg::COORD_W];

  btag_axis #(.MAX_DIM(MAX_DIM)) u_axis_s (
    .clk    (clk),
    .en     (en),
    .coord  (coord_s),
    .size   (width_r),
    .texel  (tx),
    .weight (ws),
    .dir    (ds)
  );

  btag_axis #(.MAX_DIM(MAX_DIM)) u_axis_t (
    .clk    (clk),
    .en     (en),
    .coord  (coord_t),
    .size   (height_r),
    .texel  (ty),
    .weight (wt),
    .dir    (dt)
  );

  btag_index #(.MAX_DIM(MAX_DIM), .MAX_STRIDE(MAX_STRIDE)) u_index (
    .clk              (clk),
    .en               (en),
    .tx               (tx),
    .ty               (ty),
    .ws               (ws),
    .wt               (wt),
    .ds               (ds),
    .dt               (dt),
    .width            (width_r),
    .stride           (stride_r),
    .row              (row_r),
    .index_main       (idx_main),
    .index_horizontal (idx_hor),
    .index_vertical   (idx_ver),
    .index_diagonal   (idx_diag),
    .weight_s         (weight_s),
    .weight_t         (weight_t)
  );

  assign out_tdata = {
    {(btag_pkg::OUT_TDATA_W - btag_pkg::OUT_USED_W){1'b0}},
    weight_t, weight_s, idx_diag, idx_ver, idx_hor, idx_main
  };

endmodule

// File: design/btag_axis.sv
// One axis: clamp, scale by image size (stage 1), texel/weight/neighbor (stage 2).
module btag_axis #(
  parameter int MAX_DIM = 4096,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int TX_W  = $clog2(MAX_DIM)
) (
  input  logic                                clk,
  input  btag_pkg::stage_en_t                 en,
  input  logic signed [btag_pkg::COORD_W-1:0] coord,
  input  logic [DIM_W-1:0]                    size,
  output logic [TX_W-1:0]                     texel,
  output logic [btag_pkg::WGT_W-1:0]          weight,
  output btag_pkg::nbr_dir_t                  dir
);

  localparam int P_W = btag_pkg::CLAMP_W + DIM_W;

  logic [btag_pkg::CLAMP_W-1:0] cc;
  logic [P_W-1:0]               prod_nxt, prod_r;
  logic [DIM_W-1:0]             t_raw, size_m1, t_cl;
  logic                         hit_top;
  logic [btag_pkg::CLAMP_W-1:0] frac, ctr_gap;
  logic [TX_W-1:0]              texel_nxt, texel_r;
  logic [btag_pkg::WGT_W-1:0]   weight_nxt, weight_r;
  btag_pkg::nbr_dir_t           dir_nxt, dir_r;

  // Stage 1: clamp to 0..1.0 and scale to pixel units
  always_comb begin
    if (coord[btag_pkg::COORD_W-1]) begin
      cc = '0;
    end else if (coord[btag_pkg::COORD_W-2:0] > btag_pkg::ONE_FX) begin
      cc = btag_pkg::ONE_FX;
    end else begin
      cc = coord[btag_pkg::COORD_W-2:0];
    end
    prod_nxt = P_W'(cc) * P_W'(size);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 2: integer part held to size-1; fraction becomes 1.0 at the top edge
  always_comb begin
    t_raw   = prod_r[btag_pkg::FRAC_BITS +: DIM_W];
    size_m1 = size - DIM_W'(1);
    hit_top = t_raw > size_m1;
    t_cl    = hit_top ? size_m1 : t_raw;
    frac    = hit_top ? btag_pkg::ONE_FX : {1'b0, prod_r[btag_pkg::FRAC_BITS-1:0]};
    ctr_gap = (frac >= btag_pkg::HALF_FX) ? frac - btag_pkg::HALF_FX
                                          : btag_pkg::HALF_FX - frac;
    weight_nxt = btag_pkg::WGT_W'(btag_pkg::ONE_FX - ctr_gap);
    texel_nxt  = t_cl[TX_W-1:0];
    priority if (frac < btag_pkg::HALF_FX && t_cl != '0) begin
      dir_nxt = btag_pkg::NBR_PREV;
    end else if (frac > btag_pkg::HALF_FX && t_cl != size_m1) begin
      dir_nxt = btag_pkg::NBR_NEXT;
    end else begin
      dir_nxt = btag_pkg::NBR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      texel_r  <= texel_nxt;
      weight_r <= weight_nxt;
      dir_r    <= dir_nxt;
    end
  end

  assign texel  = texel_r;
  assign weight = weight_r;
  assign dir    = dir_r;

endmodule

// File: design/btag_index.sv
// Element indices: linear pixel (stage 3), times stride (stage 4), neighbors (stage 5).
module btag_index #(
  parameter int MAX_DIM    = 4096,
  parameter int MAX_STRIDE = 4,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int TX_W  = $clog2(MAX_DIM),
  localparam int ST_W  = $clog2(MAX_STRIDE + 1)
) (
  input  logic                             clk,
  input  btag_pkg::stage_en_t              en,
  input  logic [TX_W-1:0]                  tx,
  input  logic [TX_W-1:0]                  ty,
  input  logic [btag_pkg::WGT_W-1:0]       ws,
  input  logic [btag_pkg::WGT_W-1:0]       wt,
  input  btag_pkg::nbr_dir_t               ds,
  input  btag_pkg::nbr_dir_t               dt,
  input  logic [DIM_W-1:0]                 width,
  input  logic [ST_W-1:0]                  stride,
  input  logic [btag_pkg::IDX_W-1:0]       row,
  output logic [btag_pkg::IDX_W-1:0]       index_main,
  output logic [btag_pkg::IDX_W-1:0]       index_horizontal,
  output logic [btag_pkg::IDX_W-1:0]       index_vertical,
  output logic [btag_pkg::IDX_W-1:0]       index_diagonal,
  output logic [btag_pkg::WGT_W-1:0]       weight_s,
  output logic [btag_pkg::WGT_W-1:0]       weight_t
);

  localparam int LIN_W = TX_W + DIM_W;
  localparam int MUL_W = LIN_W + ST_W;
  localparam int IW    = btag_pkg::IDX_W;

  logic [LIN_W-1:0]           lin_nxt, lin_r;
  logic [IW-1:0]              main_nxt, main_r;
  logic [btag_pkg::WGT_W-1:0] ws3_r, wt3_r, ws4_r, wt4_r;
  btag_pkg::nbr_dir_t         ds3_r, dt3_r, ds4_r, dt4_r;
  logic [IW-1:0]              hoff, voff, st_ext;
  logic [IW-1:0]              main5_r, hor_r, ver_r, diag_r;
  logic [btag_pkg::WGT_W-1:0] ws5_r, wt5_r;

  // Stage 3: pixel number in the image
  assign lin_nxt = LIN_W'(ty) * LIN_W'(width) + LIN_W'(tx);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      lin_r <= lin_nxt;
      ws3_r <= ws;
      wt3_r <= wt;
      ds3_r <= ds;
      dt3_r <= dt;
    end
  end

  // Stage 4: scale to element index, modulo the index width
  assign main_nxt = IW'(MUL_W'(lin_r) * MUL_W'(stride));

  always_ff @(posedge clk) begin
    if (en.s4) begin
      main_r <= main_nxt;
      ws4_r  <= ws3_r;
      wt4_r  <= wt3_r;
      ds4_r  <= ds3_r;
      dt4_r  <= dt3_r;
    end
  end

  // Stage 5: signed neighbor offsets, wrapping in the index width
  assign st_ext = IW'(stride);

  always_comb begin
    unique case (ds4_r)
      btag_pkg::NBR_PREV: hoff = '0 - st_ext;
      btag_pkg::NBR_NEXT: hoff = st_ext;
      default:            hoff = '0;
    endcase
    unique case (dt4_r)
      btag_pkg::NBR_PREV: voff = '0 - row;
      btag_pkg::NBR_NEXT: voff = row;
      default:            voff = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      main5_r <= main_r;
      hor_r   <= main_r + hoff;
      ver_r   <= main_r + voff;
      diag_r  <= main_r + voff + hoff;
      ws5_r   <= ws4_r;
      wt5_r   <= wt4_r;
    end
  end

  assign index_main       = main5_r;
  assign index_horizontal = hor_r;
  assign index_vertical   = ver_r;
  assign index_diagonal   = diag_r;
  assign weight_s         = ws5_r;
  assign weight_t         = wt5_r;

endmodule

// File: design/btag_checker.sv
`include "bilinear_texel_address_gen_defines.svh"

// Port-level checks on the texel address generator.
module btag_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [btag_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [btag_pkg::IDX_W-1:0] idx_main, idx_hor, idx_ver, idx_diag;
  logic [btag_pkg::IDX_W-1:0] hstep_main, hstep_ver;
  logic [btag_pkg::WGT_W-1:0] ws, wt;
  logic                       ws_ok, wt_ok;

  assign idx_main   = out_tdata[btag_pkg::OFS_MAIN +: btag_pkg::IDX_W];
  assign idx_hor    = out_tdata[btag_pkg::OFS_HOR  +: btag_pkg::IDX_W];
  assign idx_ver    = out_tdata[btag_pkg::OFS_VER  +: btag_pkg::IDX_W];
  assign idx_diag   = out_tdata[btag_pkg::OFS_DIAG +: btag_pkg::IDX_W];
  assign ws         = out_tdata[btag_pkg::OFS_WS   +: btag_pkg::WGT_W];
  assign wt         = out_tdata[btag_pkg::OFS_WT   +: btag_pkg::WGT_W];
  assign hstep_main = idx_hor - idx_main;
  assign hstep_ver  = idx_diag - idx_ver;
  assign ws_ok = (ws >= btag_pkg::HALF_FX) && (ws <= btag_pkg::ONE_FX);
  assign wt_ok = (wt >= btag_pkg::HALF_FX) && (wt <= btag_pkg::ONE_FX);

  // A stalled result holds
  `BTAG_ASSERT_NXT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready), (out_tvalid && $stable(out_tdata)), "stalled result changed")

  // Pipeline never refuses input when the output side can move
  `BTAG_ASSERT_IMP(a_in_ready, clk, rst_n, (out_tready || !out_tvalid), in_tready, "input refused with free pipeline")

  // Diagonal is the vertical neighbor shifted by the horizontal step
  `BTAG_ASSERT_IMP(a_diag_step, clk, rst_n, out_tvalid, (hstep_main == hstep_ver), "diagonal index inconsistent")

  // Weights stay within one half to one
  `BTAG_ASSERT_IMP(a_weight_rng, clk, rst_n, out_tvalid, (ws_ok && wt_ok), "weight out of range")

endmodule

bind bilinear_texel_address_gen btag_checker u_btag_checker (.*);
